FILE: src/vsc_pkg.sv
// shared types and codes for the valve status controller
`timescale 1ns / 1ps
`default_nettype none

package vsc_pkg;

    // status codes
    localparam logic [1:0] ST_CLOSED = 2'd0;
    localparam logic [1:0] ST_OPEN   = 2'd1;
    localparam logic [1:0] ST_ACTIVE = 2'd2;

    // valve types
    localparam logic [1:0] VT_PRV   = 2'd0;
    localparam logic [1:0] VT_PSV   = 2'd1;
    localparam logic [1:0] VT_CCV   = 2'd2;
    localparam logic [1:0] VT_OTHER = 2'd3;

    // event opcodes
    localparam logic [1:0] OP_RESTART = 2'd0;
    localparam logic [1:0] OP_UPDATE  = 2'd1;
    localparam logic [1:0] OP_SETTING = 2'd2;
    localparam logic [1:0] OP_STATUS  = 2'd3;

    // configuration register indexes
    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] CFG_VALVE_TYPE    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ELEVATION     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_INIT_STATUS   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_INIT_SETTING  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_ZERO_FLOW_TOL = 3'd4;

    typedef struct packed {
        logic [1:0]         valve_type;
        logic signed [31:0] elevation;
        logic [1:0]         init_status;
        logic signed [31:0] init_setting;
        logic [30:0]        zero_flow_tol;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         status;
        logic               fixed;
        logic signed [31:0] setting;
    } t_state;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] flow_q;
        logic signed [31:0] head_up;
        logic signed [31:0] head_down;
        logic signed [31:0] new_setting;
        logic [1:0]         new_status;
        logic               make_change;
    } t_event;

    typedef struct packed {
        logic accepted;
        logic flow_zeroed;
    } t_flags;

endpackage

`default_nettype wire

FILE: src/vsc_cfg_regs.sv
// configuration register file of the valve status controller
`timescale 1ns / 1ps
`default_nettype none

module vsc_cfg_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [vsc_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [31:0]                   i_cfg_wdata,
    output vsc_pkg::t_cfg                      o_cfg
);

    vsc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.valve_type    <= vsc_pkg::VT_OTHER;
            r_cfg.elevation     <= '0;
            r_cfg.init_status   <= vsc_pkg::ST_ACTIVE;
            r_cfg.init_setting  <= '0;
            r_cfg.zero_flow_tol <= 31'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                vsc_pkg::CFG_VALVE_TYPE:    r_cfg.valve_type    <= i_cfg_wdata[1:0];
                vsc_pkg::CFG_ELEVATION:     r_cfg.elevation     <= i_cfg_wdata;
                vsc_pkg::CFG_INIT_STATUS:   r_cfg.init_status   <= i_cfg_wdata[1:0];
                vsc_pkg::CFG_INIT_SETTING:  r_cfg.init_setting  <= i_cfg_wdata;
                vsc_pkg::CFG_ZERO_FLOW_TOL: r_cfg.zero_flow_tol <= i_cfg_wdata[30:0];
                default: ;  // unmapped index, ignored
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: src/vsc_event_logic.sv
// next valve state and result flags for one event
`timescale 1ns / 1ps
`default_nettype none

module vsc_event_logic (
    input  wire vsc_pkg::t_cfg   i_cfg,
    input  wire vsc_pkg::t_state i_state,
    input  wire vsc_pkg::t_event i_event,
    output vsc_pkg::t_state      o_state,
    output vsc_pkg::t_flags      o_flags
);

    function automatic logic [1:0] clamp_status(input logic [1:0] s);
        return (s == 2'd3) ? vsc_pkg::ST_ACTIVE : s;
    endfunction

    // exact 33-bit compares of heads against setting plus elevation and of flow against the negative tolerance
    logic signed [32:0] w_hset;
    logic signed [32:0] w_q;
    logic signed [32:0] w_h1;
    logic signed [32:0] w_h2;
    logic signed [32:0] w_ntol;
    logic w_rev, w_h1_lt, w_h1_gt, w_h2_lt, w_h2_gt, w_h1_gt_h2;
    logic [1:0] w_prv_next;
    logic [1:0] w_psv_next;
    logic [1:0] w_auto_next;
    logic [1:0] w_req_status;
    logic       w_silent;

    assign w_hset = {i_state.setting[31], i_state.setting}
                  + {i_cfg.elevation[31], i_cfg.elevation};
    assign w_q    = {i_event.flow_q[31], i_event.flow_q};
    assign w_h1   = {i_event.head_up[31], i_event.head_up};
    assign w_h2   = {i_event.head_down[31], i_event.head_down};
    assign w_ntol = -$signed({2'b00, i_cfg.zero_flow_tol});

    assign w_rev      = w_q < w_ntol;
    assign w_h1_lt    = w_h1 < w_hset;
    assign w_h1_gt    = w_h1 > w_hset;
    assign w_h2_lt    = w_h2 < w_hset;
    assign w_h2_gt    = w_h2 > w_hset;
    assign w_h1_gt_h2 = w_h1 > w_h2;

    // pressure reducing
    always_comb begin
        w_prv_next = i_state.status;
        if (i_state.status == vsc_pkg::ST_ACTIVE) begin
            if (w_rev)        w_prv_next = vsc_pkg::ST_CLOSED;
            else if (w_h1_lt) w_prv_next = vsc_pkg::ST_OPEN;
        end else if (i_state.status == vsc_pkg::ST_OPEN) begin
            if (w_rev)        w_prv_next = vsc_pkg::ST_CLOSED;
            else if (w_h2_gt) w_prv_next = vsc_pkg::ST_ACTIVE;
        end else begin
            if (w_h1_gt && w_h2_lt)         w_prv_next = vsc_pkg::ST_ACTIVE;
            else if (w_h1_lt && w_h1_gt_h2) w_prv_next = vsc_pkg::ST_OPEN;
        end
    end

    // pressure sustaining
    always_comb begin
        w_psv_next = i_state.status;
        if (i_state.status == vsc_pkg::ST_ACTIVE) begin
            if (w_rev)        w_psv_next = vsc_pkg::ST_CLOSED;
            else if (w_h2_gt) w_psv_next = vsc_pkg::ST_OPEN;
        end else if (i_state.status == vsc_pkg::ST_OPEN) begin
            if (w_rev)        w_psv_next = vsc_pkg::ST_CLOSED;
            else if (w_h1_lt) w_psv_next = vsc_pkg::ST_ACTIVE;
        end else begin
            if (w_h2_lt && w_h1_gt)         w_psv_next = vsc_pkg::ST_ACTIVE;
            else if (w_h2_gt && w_h1_gt_h2) w_psv_next = vsc_pkg::ST_OPEN;
        end
    end

    assign w_auto_next  = (i_cfg.valve_type == vsc_pkg::VT_PRV) ? w_prv_next : w_psv_next;
    assign w_req_status = clamp_status(i_event.new_status);
    assign w_silent     = (i_state.status == vsc_pkg::ST_CLOSED)
                       && ((i_cfg.valve_type != vsc_pkg::VT_CCV) || (i_event.new_setting == '0));

    always_comb begin
        o_state = i_state;
        o_flags = '0;
        unique case (i_event.opcode)
            vsc_pkg::OP_RESTART: begin
                o_state.status  = clamp_status(i_cfg.init_status);
                o_state.setting = i_cfg.init_setting;
                o_state.fixed   = (clamp_status(i_cfg.init_status) != vsc_pkg::ST_ACTIVE);
            end
            vsc_pkg::OP_UPDATE: begin
                if (!i_state.fixed && ((i_cfg.valve_type == vsc_pkg::VT_PRV)
                                    || (i_cfg.valve_type == vsc_pkg::VT_PSV))) begin
                    if (w_auto_next != i_state.status) begin
                        o_state.status      = w_auto_next;
                        o_flags.flow_zeroed = (w_auto_next == vsc_pkg::ST_CLOSED);
                    end
                end
            end
            vsc_pkg::OP_SETTING: begin
                if (i_state.setting != i_event.new_setting) begin
                    if (w_silent) begin
                        o_state.setting = i_event.new_setting;
                    end else begin
                        if (i_event.make_change) begin
                            if (i_event.new_setting == '0) begin
                                o_state.status      = vsc_pkg::ST_CLOSED;
                                o_flags.flow_zeroed = 1'b1;
                            end else begin
                                o_state.status = vsc_pkg::ST_OPEN;
                            end
                            o_state.setting = i_event.new_setting;
                        end
                        o_flags.accepted = 1'b1;
                    end
                end
            end
            vsc_pkg::OP_STATUS: begin
                if (!i_state.fixed || (i_state.status != w_req_status)) begin
                    if (i_event.make_change) begin
                        o_state.status      = w_req_status;
                        o_state.fixed       = 1'b1;
                        o_flags.flow_zeroed = (w_req_status == vsc_pkg::ST_CLOSED);
                    end
                    o_flags.accepted = 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

FILE: src/valve_status_controller.sv
// top level of the valve status controller: request register, state and result register
`timescale 1ns / 1ps
`default_nettype none

// channel  | handshake                | payload
// ---------+--------------------------+---------------------------------------------------
// event in | i_in_valid / o_in_ready  | opcode, flow_q, head_up, head_down, new_setting,
//          |                          | new_status, make_change
// result   | o_out_valid / i_out_ready| status_out, fixed_out, setting_out, accepted,
//          |                          | flow_zeroed
// config   | i_cfg_we (no wait)       | i_cfg_addr, i_cfg_wdata
//
// one request per cycle sustained while each result is taken as it appears
// the valve state updates when a request moves from the input register to the result
// register, so the status feedback loop closes through combinational compare logic
// reset clears the valid bits, restores the configuration defaults and sets the valve
// active, not fixed, setting zero
// a stalled result holds the result register; the input register still takes one more
// request, after which o_in_ready drops until the result is taken

module valve_status_controller (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration write port
    input  wire logic                          i_cfg_we,
    input  wire logic [vsc_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [31:0]                   i_cfg_wdata,
    // event requests
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [1:0]                    i_opcode,
    input  wire logic signed [31:0]            i_flow_q,
    input  wire logic signed [31:0]            i_head_up,
    input  wire logic signed [31:0]            i_head_down,
    input  wire logic signed [31:0]            i_new_setting,
    input  wire logic [1:0]                    i_new_status,
    input  wire logic                          i_make_change,
    // results
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [1:0]                         o_status_out,
    output logic                               o_fixed_out,
    output logic signed [31:0]                 o_setting_out,
    output logic                               o_accepted,
    output logic                               o_flow_zeroed
);

    vsc_pkg::t_cfg   w_cfg;
    vsc_pkg::t_state r_state;
    vsc_pkg::t_state n_state;
    vsc_pkg::t_flags n_flags;
    vsc_pkg::t_event r_event;
    vsc_pkg::t_flags r_flags;

    logic r_in_valid;
    logic r_out_valid;
    logic w_advance;
    logic w_take;

    // configuration registers
    vsc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    // request moves on when the result register is empty or being emptied
    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;
    assign w_take     = i_in_valid && o_in_ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_event.opcode      <= i_opcode;
            r_event.flow_q      <= i_flow_q;
            r_event.head_up     <= i_head_up;
            r_event.head_down   <= i_head_down;
            r_event.new_setting <= i_new_setting;
            r_event.new_status  <= i_new_status;
            r_event.make_change <= i_make_change;
        end
    end

    // event decode and valve state update
    vsc_event_logic u_logic (
        .i_cfg   (w_cfg),
        .i_state (r_state),
        .i_event (r_event),
        .o_state (n_state),
        .o_flags (n_flags)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.status  <= vsc_pkg::ST_ACTIVE;
            r_state.fixed   <= 1'b0;
            r_state.setting <= '0;
        end else if (w_advance) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_flags <= n_flags;
        end
    end

    // the state register doubles as the state part of the result
    assign o_out_valid   = r_out_valid;
    assign o_status_out  = r_state.status;
    assign o_fixed_out   = r_state.fixed;
    assign o_setting_out = r_state.setting;
    assign o_accepted    = r_flags.accepted;
    assign o_flow_zeroed = r_flags.flow_zeroed;

endmodule

`default_nettype wire

FILE: dv/valve_status_monitor.sv
// watches the valve status controller channels, predicts each result and compares
`timescale 1ns / 1ps

module valve_status_monitor (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [vsc_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [31:0]                   i_cfg_wdata,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [1:0]                    i_opcode,
    input  logic signed [31:0]            i_flow_q,
    input  logic signed [31:0]            i_head_up,
    input  logic signed [31:0]            i_head_down,
    input  logic signed [31:0]            i_new_setting,
    input  logic [1:0]                    i_new_status,
    input  logic                          i_make_change,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [1:0]                    i_status_out,
    input  logic                          i_fixed_out,
    input  logic signed [31:0]            i_setting_out,
    input  logic                          i_accepted,
    input  logic                          i_flow_zeroed,
    output int                            o_mismatches,
    output int                            o_pending,
    output int                            o_results
);
    import vsc_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic        fixed;
        logic [31:0] setting;
        logic        accepted;
        logic        zeroed;
    } valve_outcome_t;

    valve_outcome_t outcomes_due[$];

    // register copies
    logic [1:0]  reg_type;
    logic [31:0] reg_elev;
    logic [1:0]  reg_init_status;
    logic [31:0] reg_init_setting;
    logic [30:0] reg_tol;

    // valve copy
    logic [1:0]  valve_st;
    logic        valve_fixed;
    logic [31:0] valve_set;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
        o_results    = 0;
    end

    task automatic report(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        o_mismatches++;
    endtask

    function automatic logic [1:0] fold_status(input logic [1:0] s);
        return (s > ST_ACTIVE) ? ST_ACTIVE : s;
    endfunction

    function automatic logic [1:0] regulated_status(
        input logic [1:0]         cur,
        input logic               sustaining,
        input logic signed [32:0] q,
        input logic signed [32:0] h1,
        input logic signed [32:0] h2,
        input logic signed [32:0] hset,
        input logic signed [32:0] ntol
    );
        logic [1:0] s;
        s = cur;
        if (!sustaining) begin
            case (cur)
                ST_ACTIVE: begin
                    if (q < ntol) s = ST_CLOSED;
                    else if (h1 < hset) s = ST_OPEN;
                end
                ST_OPEN: begin
                    if (q < ntol) s = ST_CLOSED;
                    else if (h2 > hset) s = ST_ACTIVE;
                end
                default: begin
                    if (h1 > hset && h2 < hset) s = ST_ACTIVE;
                    else if (h1 < hset && h1 > h2) s = ST_OPEN;
                end
            endcase
        end else begin
            case (cur)
                ST_ACTIVE: begin
                    if (q < ntol) s = ST_CLOSED;
                    else if (h2 > hset) s = ST_OPEN;
                end
                ST_OPEN: begin
                    if (q < ntol) s = ST_CLOSED;
                    else if (h1 < hset) s = ST_ACTIVE;
                end
                default: begin
                    if (h2 < hset && h1 > hset) s = ST_ACTIVE;
                    else if (h2 > hset && h1 > h2) s = ST_OPEN;
                end
            endcase
        end
        return s;
    endfunction

    function automatic valve_outcome_t apply_event(
        input logic [1:0]         op,
        input logic signed [31:0] flow,
        input logic signed [31:0] hu,
        input logic signed [31:0] hd,
        input logic [31:0]        nset,
        input logic [1:0]         nstat,
        input logic               mk
    );
        valve_outcome_t r;
        logic [1:0]         want;
        logic signed [32:0] hset;
        logic signed [32:0] ntol;
        logic               quiet;
        r.accepted = 1'b0;
        r.zeroed   = 1'b0;
        case (op)
            OP_RESTART: begin
                valve_st    = fold_status(reg_init_status);
                valve_set   = reg_init_setting;
                valve_fixed = (valve_st != ST_ACTIVE);
            end
            OP_UPDATE: begin
                if (!valve_fixed && (reg_type == VT_PRV || reg_type == VT_PSV)) begin
                    // threshold at 33 bits so it never wraps
                    hset = $signed({valve_set[31], valve_set}) + $signed({reg_elev[31], reg_elev});
                    ntol = -$signed({2'b00, reg_tol});
                    want = regulated_status(valve_st, reg_type == VT_PSV,
                                            flow, hu, hd, hset, ntol);
                    if (want != valve_st) begin
                        r.zeroed = (want == ST_CLOSED);
                        valve_st = want;
                    end
                end
            end
            OP_SETTING: begin
                if (valve_set != nset) begin
                    quiet = (valve_st == ST_CLOSED) && (reg_type != VT_CCV || nset == '0);
                    if (quiet) begin
                        valve_set = nset;
                    end else begin
                        if (mk) begin
                            if (nset == '0) begin
                                valve_st = ST_CLOSED;
                                r.zeroed = 1'b1;
                            end else begin
                                valve_st = ST_OPEN;
                            end
                            valve_set = nset;
                        end
                        r.accepted = 1'b1;
                    end
                end
            end
            default: begin
                want = fold_status(nstat);
                if (!valve_fixed || valve_st != want) begin
                    if (mk) begin
                        valve_st    = want;
                        valve_fixed = 1'b1;
                        r.zeroed    = (want == ST_CLOSED);
                    end
                    r.accepted = 1'b1;
                end
            end
        endcase
        r.status  = valve_st;
        r.fixed   = valve_fixed;
        r.setting = valve_set;
        return r;
    endfunction

    always @(posedge i_clk) begin
        valve_outcome_t due;
        if (!i_rst_n) begin
            reg_type         = VT_OTHER;
            reg_elev         = '0;
            reg_init_status  = ST_ACTIVE;
            reg_init_setting = '0;
            reg_tol          = 31'd1;
            valve_st         = ST_ACTIVE;
            valve_fixed      = 1'b0;
            valve_set        = '0;
            outcomes_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (outcomes_due.size() == 0) begin
                    report("result with no request outstanding");
                end else begin
                    due = outcomes_due.pop_front();
                    o_results++;
                    if (i_status_out !== due.status)
                        report($sformatf("status_out %0d, want %0d", i_status_out, due.status));
                    if (i_fixed_out !== due.fixed)
                        report($sformatf("fixed_out %0b, want %0b", i_fixed_out, due.fixed));
                    if (i_setting_out !== due.setting)
                        report($sformatf("setting_out %h, want %h", i_setting_out, due.setting));
                    if (i_accepted !== due.accepted)
                        report($sformatf("accepted %0b, want %0b", i_accepted, due.accepted));
                    if (i_flow_zeroed !== due.zeroed)
                        report($sformatf("flow_zeroed %0b, want %0b", i_flow_zeroed, due.zeroed));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_VALVE_TYPE:    reg_type         = i_cfg_wdata[1:0];
                    CFG_ELEVATION:     reg_elev         = i_cfg_wdata;
                    CFG_INIT_STATUS:   reg_init_status  = i_cfg_wdata[1:0];
                    CFG_INIT_SETTING:  reg_init_setting = i_cfg_wdata;
                    CFG_ZERO_FLOW_TOL: reg_tol          = i_cfg_wdata[30:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                outcomes_due.push_back(apply_event(i_opcode, i_flow_q, i_head_up, i_head_down,
                                                   i_new_setting, i_new_status, i_make_change));
        end
        o_pending <= outcomes_due.size();
    end

endmodule

FILE: dv/testbench.sv
// stimulus and verdict for the valve status controller regression
`timescale 1ns / 1ps

module testbench;
    import vsc_pkg::*;

    // status code three is folded into active by the block
    localparam logic [1:0] ST_CODE3    = 2'd3;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         HOLD_CYCLES = 80;
    localparam int         PHASES      = 9;
    localparam int         PHASE_ITEMS = 50;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [31:0]           i_cfg_wdata;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [1:0]            i_opcode;
    logic signed [31:0]    i_flow_q;
    logic signed [31:0]    i_head_up;
    logic signed [31:0]    i_head_down;
    logic signed [31:0]    i_new_setting;
    logic [1:0]            i_new_status;
    logic                  i_make_change;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [1:0]            o_status_out;
    logic                  o_fixed_out;
    logic signed [31:0]    o_setting_out;
    logic                  o_accepted;
    logic                  o_flow_zeroed;

    int mismatches;
    int pending;
    int results_checked;
    int cycle_count = 0;
    int events_sent = 0;
    int op_count [0:3];
    int settings_used = 0;
    bit steady = 1'b0;     // no idling on either side while set
    bit hold_done = 1'b0;

    // values last written, used to aim heads and flows at the thresholds
    logic [31:0] cur_elev;
    logic [31:0] cur_init_setting;
    logic [30:0] cur_tol;

    always #2 i_clk = ~i_clk;

    valve_status_controller uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_flow_q      (i_flow_q),
        .i_head_up     (i_head_up),
        .i_head_down   (i_head_down),
        .i_new_setting (i_new_setting),
        .i_new_status  (i_new_status),
        .i_make_change (i_make_change),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status_out  (o_status_out),
        .o_fixed_out   (o_fixed_out),
        .o_setting_out (o_setting_out),
        .o_accepted    (o_accepted),
        .o_flow_zeroed (o_flow_zeroed)
    );

    valve_status_monitor status_watch (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_flow_q      (i_flow_q),
        .i_head_up     (i_head_up),
        .i_head_down   (i_head_down),
        .i_new_setting (i_new_setting),
        .i_new_status  (i_new_status),
        .i_make_change (i_make_change),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_status_out  (o_status_out),
        .i_fixed_out   (o_fixed_out),
        .i_setting_out (o_setting_out),
        .i_accepted    (o_accepted),
        .i_flow_zeroed (o_flow_zeroed),
        .o_mismatches  (mismatches),
        .o_pending     (pending),
        .o_results     (results_checked)
    );

    // run watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("valve_status_controller regression: fail");
            $finish;
        end
    end

    // mostly back-to-back, often a short pause, now and then a long one
    function automatic int idle_cycles();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // result side: random stalls plus one long hold-off while requests keep coming
    initial begin
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            int gap;
            if (!hold_done && events_sent >= 120) begin
                hold_done = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            gap = idle_cycles();
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    end

    // one request, held until the block takes it
    task automatic send_event(
        input logic [1:0]  op,
        input logic [31:0] flow,
        input logic [31:0] hu,
        input logic [31:0] hd,
        input logic [31:0] nset,
        input logic [1:0]  nstat,
        input logic        mk
    );
        int gap;
        gap = idle_cycles();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_opcode      <= op;
        i_flow_q      <= flow;
        i_head_up     <= hu;
        i_head_down   <= hd;
        i_new_setting <= nset;
        i_new_status  <= nstat;
        i_make_change <= mk;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        events_sent++;
        op_count[op]++;
    endtask

    // drop valid and wait until every result is back
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
    endtask

    // all five registers, unused upper bits filled with noise
    task automatic set_valve(
        input logic [1:0]  vt,
        input logic [31:0] elev,
        input logic [1:0]  st,
        input logic [31:0] init_set,
        input logic [30:0] tol
    );
        logic [31:0] noise;
        noise = $urandom();
        cfg_write(CFG_VALVE_TYPE, {noise[31:2], vt});
        cfg_write(CFG_ELEVATION, elev);
        cfg_write(CFG_INIT_STATUS, {noise[29:0], st});
        cfg_write(CFG_INIT_SETTING, init_set);
        cfg_write(CFG_ZERO_FLOW_TOL, {noise[7], tol});
        i_cfg_we <= 1'b0;
        cur_elev         = elev;
        cur_init_setting = init_set;
        cur_tol          = tol;
        settings_used++;
    endtask

    function automatic logic [31:0] extreme_word();
        case ($urandom_range(0, 3))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // a value within span of center, saturated to 32 bits
    function automatic logic [31:0] near(input logic signed [33:0] center, input int span);
        int d;
        logic signed [33:0] v;
        d = $urandom_range(0, 2 * span);
        d = d - span;
        v = center + d;
        if (v > 34'sh07FFF_FFFF) return 32'h7FFF_FFFF;
        if (v < -34'sh08000_0000) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0:       return $urandom();
            1:       return extreme_word();
            default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        endcase
    endfunction

    function automatic logic [1:0] pick_type();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return VT_PRV;
        if (r < 80) return VT_PSV;
        if (r < 90) return VT_CCV;
        return VT_OTHER;
    endfunction

    function automatic logic [1:0] pick_init_status();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return ST_ACTIVE;
        if (r < 75) return ST_CODE3;
        if (r < 88) return ST_OPEN;
        return ST_CLOSED;
    endfunction

    function automatic logic [30:0] pick_tol();
        logic [31:0] w;
        case ($urandom_range(0, 4))
            0:       w = 32'h0;
            1:       w = 32'h7FFF_FFFF;
            2:       w = $urandom();
            default: w = $urandom_range(0, 32'h0001_0000);
        endcase
        return w[30:0];
    endfunction

    // heads land mostly right around setting plus elevation
    function automatic logic [31:0] pick_head(input logic signed [33:0] base);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return $urandom();
        if (r == 1) return extreme_word();
        return near(base, 4);
    endfunction

    // flows land mostly positive, often right at the reverse-flow limit
    function automatic logic [31:0] pick_flow(input logic signed [33:0] ntol);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return $urandom();
        if (r == 1) return extreme_word();
        if (r < 4) return near(ntol, 2);
        return $urandom_range(0, 32'h0010_0000);
    endfunction

    function automatic logic [31:0] pick_setting();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) return 32'h0;
        if (r == 3) return cur_init_setting;
        if (r == 4) return extreme_word();
        if (r == 5) return $urandom();
        return near($signed(cur_init_setting), 3);
    endfunction

    task automatic send_random_event(input bit restart);
        logic [1:0] op;
        int r;
        logic signed [33:0] head_base;
        logic signed [33:0] ntol;
        logic [31:0] flow, hu, hd, nset;
        logic [1:0] nstat;
        logic mk;
        head_base = $signed(cur_init_setting) + $signed(cur_elev);
        ntol      = -$signed({3'b000, cur_tol});
        r = $urandom_range(0, 99);
        if (restart || r < 10) op = OP_RESTART;
        else if (r < 60)       op = OP_UPDATE;
        else if (r < 80)       op = OP_SETTING;
        else                   op = OP_STATUS;
        flow  = pick_flow(ntol);
        hu    = pick_head(head_base);
        hd    = pick_head(head_base);
        nset  = pick_setting();
        nstat = $urandom_range(0, 3);
        mk    = ($urandom_range(0, 9) < 7);
        send_event(op, flow, hu, hd, nset, nstat, mk);
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_addr    <= '0;
        i_cfg_wdata   <= '0;
        i_in_valid    <= 1'b0;
        i_opcode      <= OP_RESTART;
        i_flow_q      <= '0;
        i_head_up     <= '0;
        i_head_down   <= '0;
        i_new_setting <= '0;
        i_new_status  <= ST_ACTIVE;
        i_make_change <= 1'b0;
        cur_elev         = '0;
        cur_init_setting = '0;
        cur_tol          = 31'd1;
        for (int k = 0; k < 4; k++) op_count[k] = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset registers: other valve type, so updates leave the status alone
        send_event(OP_UPDATE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, ST_CLOSED, 1'b1);
        send_event(OP_RESTART, '1, '1, '1, '1, ST_CODE3, 1'b1);
        // status code three on a free valve reports a change without making it
        send_event(OP_STATUS, 0, 0, 0, 0, ST_CODE3, 1'b0);
        send_event(OP_STATUS, 0, 0, 0, 0, ST_CLOSED, 1'b1);
        // fixed and already closed: nothing to do
        send_event(OP_STATUS, 0, 0, 0, 0, ST_CLOSED, 1'b1);
        send_event(OP_SETTING, 0, 0, 0, 32'h0, ST_OPEN, 1'b1);
        // closed valve takes a new setting silently
        send_event(OP_SETTING, 0, 0, 0, 32'h7FFF_FFFF, ST_OPEN, 1'b1);
        send_event(OP_STATUS, 0, 0, 0, 0, ST_OPEN, 1'b1);
        // report-only setting change, then the real one
        send_event(OP_SETTING, 0, 0, 0, 32'h8000_0000, ST_OPEN, 1'b0);
        send_event(OP_SETTING, 0, 0, 0, 32'h8000_0000, ST_OPEN, 1'b1);
        // zero setting closes the valve and zeroes the flow
        send_event(OP_SETTING, 0, 0, 0, 32'h0, ST_OPEN, 1'b1);
        drain();

        // reducing valve with every threshold term at its top, threshold needs 33 bits
        set_valve(VT_PRV, 32'h7FFF_FFFF, ST_CODE3, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
        send_event(OP_RESTART, 0, 0, 0, 0, ST_ACTIVE, 1'b0);
        send_event(OP_UPDATE, 32'h8000_0000, 0, 0, 0, ST_ACTIVE, 1'b0);
        send_event(OP_RESTART, 0, 0, 0, 0, ST_ACTIVE, 1'b0);
        send_event(OP_UPDATE, 32'h0, 32'h7FFF_FFFF, 32'h0, 0, ST_ACTIVE, 1'b0);
        send_event(OP_UPDATE, 32'h0, 32'h0, 32'h7FFF_FFFF, 0, ST_ACTIVE, 1'b0);
        drain();

        // closure control valve, everything at the bottom
        set_valve(VT_CCV, 32'h8000_0000, ST_CLOSED, 32'h8000_0000, 31'h0);
        send_event(OP_RESTART, 0, 0, 0, 0, ST_ACTIVE, 1'b0);
        // closed closure control valve only goes quiet for a zero setting
        send_event(OP_SETTING, 0, 0, 0, 32'h0000_0007, ST_ACTIVE, 1'b1);
        send_event(OP_SETTING, 0, 0, 0, 32'h0, ST_ACTIVE, 1'b1);
        send_event(OP_SETTING, 0, 0, 0, 32'h0000_0009, ST_ACTIVE, 1'b0);
        send_event(OP_UPDATE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, ST_ACTIVE, 1'b0);
        drain();

        // sustaining valve walked around its status loop
        set_valve(VT_PSV, 32'h0, ST_ACTIVE, 32'h0001_0000, 31'd1);
        send_event(OP_RESTART, 0, 0, 0, 0, ST_ACTIVE, 1'b0);
        send_event(OP_UPDATE, 32'h1, 32'h0002_0000, 32'h0002_0000, 0, ST_ACTIVE, 1'b0);
        send_event(OP_UPDATE, 32'h1, 32'h0000_8000, 32'h0, 0, ST_ACTIVE, 1'b0);
        send_event(OP_UPDATE, 32'hFFFF_FFFE, 32'h0, 32'h0, 0, ST_ACTIVE, 1'b0);
        send_event(OP_UPDATE, 32'h5, 32'h0002_0000, 32'h0000_8000, 0, ST_ACTIVE, 1'b0);
        drain();

        // random phases, each starting from a restart under a fresh setting
        for (int p = 0; p < PHASES; p++) begin
            steady = (p == 2 || p == 6);
            case (p)
                3: set_valve(VT_PSV, 32'h7FFF_FFFF, ST_CODE3, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
                4: set_valve(VT_PRV, 32'h8000_0000, ST_ACTIVE, 32'h8000_0000, 31'h0);
                default: set_valve(pick_type(), pick_word(), pick_init_status(), pick_word(),
                                   pick_tol());
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_random_event(n == 0);
            drain();
        end
        steady = 1'b0;

        // a little extra time for any stray result
        repeat (10) @(posedge i_clk);

        $display("sent %0d requests (restart %0d, update %0d, setting %0d, status %0d)",
                 events_sent, op_count[OP_RESTART], op_count[OP_UPDATE],
                 op_count[OP_SETTING], op_count[OP_STATUS]);
        $display("%0d results compared over %0d register settings, %0d mismatches",
                 results_checked, settings_used, mismatches);
        if (mismatches == 0) begin
            $display("valve_status_controller regression: pass");
        end else begin
            $display("valve_status_controller regression: fail");
        end
        $finish;
    end

endmodule
